### hdl/sorted_byte_list_macros.svh
// Assertion macros for the sorted byte list.
// Depends on a clock named clock and a reset named reset in the using scope.
`ifndef SORTED_BYTE_LIST_MACROS_SVH
`define SORTED_BYTE_LIST_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SBL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SBL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/sbl_pkg.sv
// Types and codes shared by the sorted byte list cells and top level.
// No dependencies.
package sbl_pkg;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_DELETE = 1'b1;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_FULL      = 3'd1,
      ST_DELETED   = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] value;
   } sbl_req_type;

   typedef struct packed {
      status_type status;
      logic [3:0] position;
      logic [4:0] entry_count;
   } sbl_rsp_type;

   // Broadcast from the top level to every cell.
   typedef struct packed {
      logic       insert_en;
      logic       delete_en;
      logic [7:0] value;
   } sbl_ctrl_type;

endpackage

### hdl/sorted_byte_list.sv
// Sorted byte list: ascending list of bytes, duplicates allowed, in a row of
// CAPACITY cells. Each beat on the request side inserts or deletes one value.
//
// Request: a beat is taken at a rising edge with start high and busy low.
// req_data.mode selects insert or delete, req_data.value is the byte.
// Response: rsp_valid is high for one cycle with status, position and the
// new entry count in rsp_data; there is no back-pressure.
// Timing: the request is registered, every cell compares against it in the
// next cycle and shifts at the edge after, where the response and rsp_valid
// are registered too. One beat is taken every cycle while busy is low; the
// next beat compares against the row as the previous beat leaves it.
// Reset: synchronous, active high; the count goes to zero (cell contents are
// don't-care until written) and busy is high until an edge sees reset low.
// Position and entry count are reported modulo 16 and 32 for large rows.
`include "sorted_byte_list_macros.svh"

module sorted_byte_list #(
   parameter int CAPACITY = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  sbl_pkg::sbl_req_type req_data,
   output logic                 rsp_valid,
   output sbl_pkg::sbl_rsp_type rsp_data
);
   import sbl_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int POS_W = (IDX_W > 4) ? IDX_W : 4;
   localparam int ECW   = (CNT_W > 5) ? CNT_W : 5;

   logic              busy_ff;
   logic              req_valid_ff;
   sbl_req_type       req_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              rsp_valid_ff;
   sbl_rsp_type       rsp_ff;
   sbl_rsp_type       rsp_in;

   sbl_ctrl_type      ctrl;
   logic [7:0]        cell_val [CAPACITY];
   logic [CAPACITY-1:0] occ;
   logic [CAPACITY-1:0] gt;
   logic [CAPACITY-1:0] eq;
   logic [CAPACITY-1:0] bnd;
   logic [IDX_W-1:0]  slot;
   logic              found;
   logic              full;
   logic              empty;
   logic [POS_W-1:0]  pos_ext;
   logic [ECW-1:0]    cnt_ext;

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   // row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic       left_gt;
      logic [7:0] left_val;
      logic [7:0] right_val;

      assign occ[i] = count_ff > CNT_W'(i);
      if (i == 0) begin : g_first
         assign left_gt  = 1'b1;
         assign left_val = req_ff.value;
         assign bnd[i]   = !gt[i];
      end else begin : g_inner
         assign left_gt  = gt[i-1];
         assign left_val = cell_val[i-1];
         assign bnd[i]   = !gt[i] && gt[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_val = cell_val[i];
      end else begin : g_mid
         assign right_val = cell_val[i+1];
      end

      sbl_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (occ[i]),
         .left_gt   (left_gt),
         .left_val  (left_val),
         .right_val (right_val),
         .val       (cell_val[i]),
         .gt        (gt[i]),
         .eq        (eq[i])
      );
   end

   // boundary has at most one bit set: first cell not below the value
   always_comb begin
      slot = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (bnd[i]) begin
            slot = slot | IDX_W'(i);
         end
      end
   end

   assign found = |(bnd & eq);

   always_comb begin
      ctrl.value     = req_ff.value;
      ctrl.insert_en = req_valid_ff && (req_ff.mode == MODE_INSERT) && !full;
      ctrl.delete_en = req_valid_ff && (req_ff.mode == MODE_DELETE) && found;
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.delete_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      pos_ext = '0;
      if (ctrl.insert_en || ctrl.delete_en) begin
         pos_ext = POS_W'(slot);
      end
      cnt_ext = ECW'(count_in);
      rsp_in.position    = pos_ext[3:0];
      rsp_in.entry_count = cnt_ext[4:0];
      unique case (req_ff.mode)
         MODE_INSERT: rsp_in.status = full ? ST_FULL : ST_INSERTED;
         MODE_DELETE: begin
            priority if (empty) begin
               rsp_in.status = ST_EMPTY;
            end else if (!found) begin
               rsp_in.status = ST_NOT_FOUND;
            end else begin
               rsp_in.status = ST_DELETED;
            end
         end
         default:     rsp_in.status = ST_NOT_FOUND;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         busy_ff      <= 1'b0;
         req_valid_ff <= start && !busy_ff;
         rsp_valid_ff <= req_valid_ff;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         req_ff <= req_data;
      end
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   `SBL_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(CAPACITY), "count beyond capacity")
   `SBL_ASSERT_NEXT(a_rsp_follows, start && !busy, ##1 rsp_valid, "accepted beat gave no response")
   `SBL_ASSERT_NOW(a_insert_count, rsp_valid && (rsp_data.status == ST_INSERTED),
                   count_ff == CNT_W'($past(count_ff) + CNT_W'(1)), "insert did not grow count")
   `SBL_ASSERT_NOW(a_no_change, rsp_valid && (rsp_data.status == ST_FULL ||
                   rsp_data.status == ST_NOT_FOUND || rsp_data.status == ST_EMPTY),
                   $stable(count_ff), "refused beat changed count")

endmodule

### hdl/sbl_cell.sv
// One list cell: holds a byte, compares it with the broadcast value and
// takes a neighbour's byte when the list shifts. Depends on sbl_pkg.
module sbl_cell (
   input  logic                  clock,
   input  sbl_pkg::sbl_ctrl_type ctrl,
   input  logic                  occupied,
   input  logic                  left_gt,
   input  logic [7:0]            left_val,
   input  logic [7:0]            right_val,
   output logic [7:0]            val,
   output logic                  gt,
   output logic                  eq
);
   import sbl_pkg::*;

   logic [7:0] val_ff;
   logic [7:0] val_in;

   assign val = val_ff;
   assign gt  = occupied && (ctrl.value > val_ff);
   assign eq  = occupied && (ctrl.value == val_ff);

   always_comb begin
      val_in = val_ff;
      if (ctrl.insert_en) begin
         // cells before the slot keep, the slot takes the value, the rest move up
         if (!gt) begin
            val_in = left_gt ? ctrl.value : left_val;
         end
      end else if (ctrl.delete_en) begin
         // from the removed entry onwards pull down from the right
         if (!gt) begin
            val_in = right_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

### sim/sorted_byte_list_test.sv
`timescale 1ns / 1ps
// Self-checking bench for sorted_byte_list: directed and random insert/delete beats.
// Every response is checked against an in-bench model of the sorted store.
// Depends on sbl_pkg and the sorted_byte_list RTL.
module sorted_byte_list_test;
   import sbl_pkg::*;

   localparam int CAPACITY = 16;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_BEATS = 650;

   class sorted_list_board;
      logic [7:0] entries[$];
      sbl_rsp_type pending_replies[$];
      int mismatch_count;

      task report(string line);
         mismatch_count++;
         $display("%0t: %s", $time, line);
      endtask

      // Applies one insert or delete to the store and returns the reply it should give.
      function sbl_rsp_type apply_edit(sbl_req_type req);
         sbl_rsp_type r;
         int slot;
         int n;
         r = '0;
         slot = 0;
         if (req.mode == MODE_INSERT) begin
            if (entries.size() >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               // an equal value goes ahead of the ones already stored
               while (slot < entries.size() && req.value > entries[slot]) slot++;
               entries.insert(slot, req.value);
               r.status = ST_INSERTED;
               r.position = slot[3:0];
            end
         end else if (entries.size() == 0) begin
            r.status = ST_EMPTY;
         end else begin
            while (slot < entries.size() && entries[slot] != req.value) slot++;
            if (slot == entries.size()) begin
               r.status = ST_NOT_FOUND;
            end else begin
               entries.delete(slot);
               r.status = ST_DELETED;
               r.position = slot[3:0];
            end
         end
         n = entries.size();
         r.entry_count = n[4:0];
         return r;
      endfunction

      function void note_request(sbl_req_type req);
         pending_replies.push_back(apply_edit(req));
      endfunction

      task check_result(sbl_rsp_type got);
         sbl_rsp_type want;
         if (pending_replies.size() == 0) begin
            report($sformatf("response with none outstanding: status %0d pos %0d count %0d",
                             got.status, got.position, got.entry_count));
         end else begin
            want = pending_replies.pop_front();
            if (got.status !== want.status)
               report($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.position !== want.position)
               report($sformatf("position %0d, expected %0d", got.position, want.position));
            if (got.entry_count !== want.entry_count)
               report($sformatf("entry_count %0d, expected %0d", got.entry_count,
                                want.entry_count));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   sbl_req_type req_data = '0;
   logic busy;
   logic rsp_valid;
   sbl_rsp_type rsp_data;
   int idle_run = 0;
   sorted_list_board board = new();

   always #5 clock = ~clock;

   sorted_byte_list #(.CAPACITY(CAPACITY)) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   // responses belong to earlier beats, so check before noting this edge's beat
   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_result(rsp_data);
      if (!reset && start && !busy) board.note_request(req_data);
      if (reset || rsp_valid || (start && !busy)) begin
         idle_run <= 0;
      end else if (idle_run >= STALL_LIMIT) begin
         $display("sorted_byte_list regression: fail");
         $finish;
      end else begin
         idle_run <= idle_run + 1;
      end
   end

   function automatic sbl_req_type beat_of(logic mode, logic [7:0] value);
      sbl_req_type r;
      r.mode = mode;
      r.value = value;
      return r;
   endfunction

   // Inserts lean to extremes and duplicates; deletes mostly name a stored value.
   function automatic sbl_req_type random_beat(int insert_pct);
      sbl_req_type r;
      int n;
      n = board.entries.size();
      r.mode = ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_DELETE;
      if (r.mode == MODE_INSERT) begin
         case ($urandom_range(9))
            0, 1, 2, 3: r.value = 8'($urandom_range(255));
            4, 5: r.value = $urandom_range(1) ? 8'($urandom_range(3))
                                              : 8'($urandom_range(255, 252));
            default: r.value = (n > 0) ? board.entries[$urandom_range(n - 1)]
                                       : 8'($urandom_range(255));
         endcase
      end else begin
         if (n > 0 && $urandom_range(9) < 7) r.value = board.entries[$urandom_range(n - 1)];
         else r.value = 8'($urandom_range(255));
      end
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_beat(sbl_req_type req, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= req;
      do @(posedge clock); while (!(start && !busy));
      @(negedge clock);
   endtask

   // Bursts that fill, drain or churn the store so full and empty both come round often.
   task automatic run_phase(int beats, int idle_pct);
      int sent;
      int burst;
      int bias;
      sent = 0;
      while (sent < beats) begin
         case ($urandom_range(2))
            0: bias = 85;
            1: bias = 20;
            default: bias = 55;
         endcase
         burst = $urandom_range(40, 5);
         repeat (burst) begin
            send_beat(random_beat(bias), idle_pct);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_beat(beat_of(MODE_DELETE, 8'h00), 0);     // empty list
      send_beat(beat_of(MODE_INSERT, 8'hFF), 0);
      send_beat(beat_of(MODE_INSERT, 8'h00), 0);
      send_beat(beat_of(MODE_INSERT, 8'h00), 0);     // duplicate lands at the front
      send_beat(beat_of(MODE_INSERT, 8'h80), 0);
      for (int i = 0; i < 12; i++) send_beat(beat_of(MODE_INSERT, 8'(i * 21 + 5)), 0);
      send_beat(beat_of(MODE_INSERT, 8'h40), 0);     // store full, refused
      send_beat(beat_of(MODE_DELETE, 8'h00), 0);
      send_beat(beat_of(MODE_DELETE, 8'h55), 0);     // absent
      send_beat(beat_of(MODE_DELETE, 8'hFF), 0);

      run_phase(PHASE_BEATS, 21);
      run_phase(PHASE_BEATS, 68);
      run_phase(PHASE_BEATS, 0);
      start <= 1'b0;

      while (board.pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatch_count == 0) begin
         $display("sorted_byte_list regression: pass");
      end else begin
         $display("sorted_byte_list regression: fail");
      end
      $finish;
   end

endmodule

### files.f
+incdir+hdl
hdl/sbl_pkg.sv
hdl/sbl_cell.sv
hdl/sorted_byte_list.sv
sim/sorted_byte_list_test.sv
